// ===== rtl/spiir_pkg.sv =====
// ----------------------------------------------------------------------------
// spiir_pkg
// Shared widths, register indexes and types for the single-pole IIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package spiir_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SCALE_W  = 15;
   localparam int KDIV_W   = 16;
   localparam int ACC_W    = 32;
   localparam int CSR_W    = 16;

   localparam logic CSR_SCALE = 1'b0;
   localparam logic CSR_KDIV  = 1'b1;

   localparam logic [SAMPLE_W-1:0] OUT_MAX = '1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== rtl/spiir_div.sv =====
// ----------------------------------------------------------------------------
// spiir_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spiir_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [spiir_pkg::ACC_W-1:0]  dividend,
   input  wire logic [spiir_pkg::KDIV_W-1:0] divisor,
   output logic      [spiir_pkg::ACC_W-1:0]  quotient,
   output spiir_pkg::div_status_type         status
);
   import spiir_pkg::*;

   localparam int CNT_W = $clog2(ACC_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ACC_W-1:0]    quo_ff, quo_in;
   logic [KDIV_W-1:0]   rem_ff, rem_in;
   logic [KDIV_W-1:0]   dvs_ff, dvs_in;

   logic [KDIV_W:0]     rem_sh;
   logic [KDIV_W:0]     trial;
   logic                ge;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[ACC_W-1]};
      ge     = rem_sh >= {1'b0, dvs_ff};
      trial  = rem_sh - {1'b0, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;

      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[ACC_W-2:0], ge};
         rem_in = ge ? trial[KDIV_W-1:0] : rem_sh[KDIV_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ACC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ===== rtl/single_pole_iir_integer_filter.sv =====
// ----------------------------------------------------------------------------
// single_pole_iir_integer_filter
// Integer exponential moving average of unsigned 16-bit readings.
// ----------------------------------------------------------------------------
// Steps from item accept to rsp_tvalid: a shift-add multiply of sample by
// scale, then two passes of the shared serial divider (correction / k, then
// accumulator / scale), plus control steps. A new item is accepted only in
// idle, once the last one is through; the next item is taken while a result
// waits on rsp. Reset clears the accumulator, the seeded flag and sets both
// registers to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module single_pole_iir_integer_filter (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [spiir_pkg::SAMPLE_W-1:0] req_tdata,   // [15:0] sample
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [spiir_pkg::SAMPLE_W-1:0] rsp_tdata,   // [15:0] filtered
   input  wire logic                           csr_wr_en,
   input  wire logic                           csr_index,
   input  wire logic [spiir_pkg::CSR_W-1:0]    csr_wdata
);
   import spiir_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL  = 7'b0000010,
      ST_DIFF = 7'b0000100,
      ST_QUO  = 7'b0001000,
      ST_SCL  = 7'b0010000,
      ST_RES  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   logic [SCALE_W-1:0]     scale_ff, scale_in;
   logic [KDIV_W-1:0]      kdiv_ff, kdiv_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic                   primed_ff, primed_in;
   logic [ACC_W-1:0]       prod_ff, prod_in;
   logic [ACC_W-1:0]       mcand_ff, mcand_in;
   logic [SAMPLE_W-1:0]    mplier_ff, mplier_in;
   logic [3:0]             cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]    rsp_data_ff, rsp_data_in;

   logic [SCALE_W-1:0]     gain;
   logic [KDIV_W-1:0]      kval;
   logic [ACC_W-1:0]       acc_base;
   logic [ACC_W:0]         diff;
   logic [ACC_W:0]         diff_neg;
   logic                   div_start;
   logic [ACC_W-1:0]       div_dividend;
   logic [KDIV_W-1:0]      div_divisor;
   logic [ACC_W-1:0]       div_quotient;
   div_status_type         div_stat;

   assign gain = (scale_ff == '0) ? SCALE_W'(1) : scale_ff;
   assign kval = (kdiv_ff == '0) ? KDIV_W'(1) : kdiv_ff;

   spiir_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_stat)
   );

   always_comb begin
      state_in     = state_ff;
      scale_in     = scale_ff;
      kdiv_in      = kdiv_ff;
      acc_in       = acc_ff;
      primed_in    = primed_ff;
      prod_in      = prod_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = kval;

      acc_base = primed_ff ? acc_ff : prod_ff;
      diff     = {1'b0, prod_ff} - {1'b0, acc_base};
      diff_neg = '0 - diff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_SCALE: scale_in = csr_wdata[SCALE_W-1:0];
            CSR_KDIV:  kdiv_in  = csr_wdata[KDIV_W-1:0];
            default:   ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               prod_in   = '0;
               mcand_in  = ACC_W'(gain);
               mplier_in = req_tdata;
               cnt_in    = '0;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mplier_ff[0]) begin
               prod_in = prod_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[ACC_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[SAMPLE_W-1:1]};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == 4'hF) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            acc_in       = acc_base;
            primed_in    = 1'b1;
            neg_in       = diff[ACC_W];
            div_start    = 1'b1;
            div_dividend = diff[ACC_W] ? diff_neg[ACC_W-1:0] : diff[ACC_W-1:0];
            div_divisor  = kval;
            state_in     = ST_QUO;
         end
         ST_QUO: begin
            if (div_stat.done) begin
               acc_in   = neg_ff ? (acc_ff - div_quotient) : (acc_ff + div_quotient);
               state_in = ST_SCL;
            end
         end
         ST_SCL: begin
            div_start    = 1'b1;
            div_dividend = acc_ff;
            div_divisor  = KDIV_W'(gain);
            state_in     = ST_RES;
         end
         ST_RES: begin
            if (div_stat.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // quotient holds while the divider is idle
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = (div_quotient[ACC_W-1:SAMPLE_W] != '0) ? OUT_MAX
                                                                     : div_quotient[SAMPLE_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scale_ff     <= SCALE_W'(1);
         kdiv_ff      <= KDIV_W'(1);
         acc_ff       <= '0;
         primed_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scale_ff     <= scale_in;
         kdiv_ff      <= kdiv_in;
         acc_ff       <= acc_in;
         primed_ff    <= primed_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff     <= prod_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_acc_range : assert property (@(posedge clock) disable iff (reset)
      !acc_ff[ACC_W-1])
      else $error("accumulator out of range");

   a_div_done_state : assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_QUO || state_ff == ST_RES))
      else $error("divider finished outside a wait state");

   a_primed_after_diff : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIFF) |=> primed_ff)
      else $error("filter not seeded after first item");

   a_div_idle_on_start : assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

endmodule

`default_nettype wire
